// ===== rtl/wrss_pkg.sv =====
`timescale 1ns / 1ps

package wrss_pkg;

  // Field and register widths.
  localparam int unsigned ID_W      = 8;
  localparam int unsigned LAT_W     = 10;
  localparam int unsigned LOSS_W    = 14;
  localparam int unsigned LOAD_W    = 7;
  localparam int unsigned TREND_W   = 16;
  localparam int unsigned WEIGHT_W  = 16;
  localparam int unsigned SCORE_W   = 18;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 18;

  // A term in Q0.16 runs from 0 to 1.0 inclusive, so it needs 17 bits.
  localparam int unsigned TERM_W    = 17;
  localparam int unsigned Q16_ONE   = 65536;

  // Sum of four weight * term products stays below 2^34.
  localparam int unsigned ACC_W     = 34;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_W_LATENCY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_W_LOSS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_W_STABILITY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_W_TREND     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd4;

  // Register reset values.
  localparam logic [WEIGHT_W-1:0]  RST_W_LATENCY   = 16'd32768;
  localparam logic [WEIGHT_W-1:0]  RST_W_LOSS      = 16'd19661;
  localparam logic [WEIGHT_W-1:0]  RST_W_STABILITY = 16'd6554;
  localparam logic [WEIGHT_W-1:0]  RST_W_TREND     = 16'd6554;
  localparam logic [SCORE_W-1:0]   RST_THRESHOLD   = 18'd0;

  // Normalization points of the falling terms.
  localparam int unsigned WORST_LAT_MS = 250;
  localparam int unsigned WORST_LOSS   = 1500;
  localparam int unsigned LOAD_FULL    = 100;

  // Width of (worst - clamped value) for each falling term.
  localparam int unsigned LAT_DW  = $clog2(WORST_LAT_MS + 1);
  localparam int unsigned LOSS_DW = $clog2(WORST_LOSS + 1);
  localparam int unsigned LOAD_DW = $clog2(LOAD_FULL + 1);

  // floor(d * 2^16 / W) is computed as (d * ceil(2^(16+S) / W)) >> S.
  // With 2^S >= W*W and d <= W the rounding error never crosses an integer.
  localparam int unsigned LAT_SHIFT  = $clog2(WORST_LAT_MS * WORST_LAT_MS);
  localparam int unsigned LOSS_SHIFT = $clog2(WORST_LOSS * WORST_LOSS);
  localparam int unsigned LOAD_SHIFT = $clog2(LOAD_FULL * LOAD_FULL);

  localparam longint unsigned LAT_RECIP =
      ((64'd1 << (16 + LAT_SHIFT)) + WORST_LAT_MS - 1) / WORST_LAT_MS;
  localparam longint unsigned LOSS_RECIP =
      ((64'd1 << (16 + LOSS_SHIFT)) + WORST_LOSS - 1) / WORST_LOSS;
  localparam longint unsigned LOAD_RECIP =
      ((64'd1 << (16 + LOAD_SHIFT)) + LOAD_FULL - 1) / LOAD_FULL;

  localparam int unsigned LAT_RECIP_W  = $clog2(LAT_RECIP + 1);
  localparam int unsigned LOSS_RECIP_W = $clog2(LOSS_RECIP + 1);
  localparam int unsigned LOAD_RECIP_W = $clog2(LOAD_RECIP + 1);

  // Shared multiplier: the A side takes reciprocals or weights, the B side
  // takes differences or terms.
  localparam int unsigned RECIP_W0 =
      (LAT_RECIP_W > LOSS_RECIP_W) ? LAT_RECIP_W : LOSS_RECIP_W;
  localparam int unsigned RECIP_W1 =
      (RECIP_W0 > LOAD_RECIP_W) ? RECIP_W0 : LOAD_RECIP_W;
  localparam int unsigned MUL_A_W = (RECIP_W1 > WEIGHT_W) ? RECIP_W1 : WEIGHT_W;
  localparam int unsigned MUL_B_W = TERM_W;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 32;

endpackage

// ===== rtl/weighted_route_score_selector.sv =====
// Route score selector. Candidates arrive as beats on the slave stream; each
// beat carries the route id, latency, loss, load and trend in tdata, the
// in-use mark in tuser and the end of the candidate set in tlast. Every
// candidate gets a weighted score in unsigned Q.16 from four Q0.16 terms,
// and the block keeps the best one, the first seen winning a tie. The beat
// that ends a set yields one result beat with the best route, its score, a
// switch flag (best above in-use score plus threshold, or no in-use route)
// and whether an in-use route was seen; other beats yield nothing. One
// multiplier serves all seven products of a candidate (three normalizing
// reciprocal products, then four weight products) in sequence; the input is
// ready again only when the sequencer is back in idle, so no new beat is
// taken before the last candidate is through. A set-ending beat waits in its
// last step while an earlier result beat still stalls on the output register.
// The user must write weights and threshold through the plain register port
// only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module weighted_route_score_selector (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [wrss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wrss_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  // Candidate stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: route_id[7:0], latency_ms[17:8], loss_rate[31:18],
  //        load_percent[38:32], trend[54:39], zero pad[55]
  input  logic [wrss_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: is_current[0]
  input  logic                            s_axis_tuser,
  input  logic                            s_axis_tlast,
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: best_route[7:0], best_score[25:8], switch_route[26],
  //        current_found[27], zero pad[31:28]
  output logic [wrss_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned IdW     = wrss_pkg::ID_W;
  localparam int unsigned LatW    = wrss_pkg::LAT_W;
  localparam int unsigned LossW   = wrss_pkg::LOSS_W;
  localparam int unsigned LoadW   = wrss_pkg::LOAD_W;
  localparam int unsigned TrendW  = wrss_pkg::TREND_W;
  localparam int unsigned WeightW = wrss_pkg::WEIGHT_W;
  localparam int unsigned ScoreW  = wrss_pkg::SCORE_W;
  localparam int unsigned TermW   = wrss_pkg::TERM_W;
  localparam int unsigned AccW    = wrss_pkg::ACC_W;
  localparam int unsigned LatDW   = wrss_pkg::LAT_DW;
  localparam int unsigned LossDW  = wrss_pkg::LOSS_DW;
  localparam int unsigned LoadDW  = wrss_pkg::LOAD_DW;
  localparam int unsigned MulAW   = wrss_pkg::MUL_A_W;
  localparam int unsigned MulBW   = wrss_pkg::MUL_B_W;
  localparam int unsigned ProdW   = wrss_pkg::PROD_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL_LAT  = 4'd1;
  localparam logic [3:0] S_MUL_LOSS = 4'd2;
  localparam logic [3:0] S_MUL_LOAD = 4'd3;
  localparam logic [3:0] S_W_LAT    = 4'd4;
  localparam logic [3:0] S_W_LOSS   = 4'd5;
  localparam logic [3:0] S_W_LOAD   = 4'd6;
  localparam logic [3:0] S_W_TREND  = 4'd7;
  localparam logic [3:0] S_ACC      = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  // Configuration registers.
  logic [WeightW-1:0] w_lat_q, w_loss_q, w_stab_q, w_trend_q;
  logic [ScoreW-1:0]  thr_q;

  // Sequencer and captured candidate.
  logic [3:0]         state_q, state_d;
  logic [IdW-1:0]     id_q;
  logic [LatDW-1:0]   d_lat_q;
  logic [LossDW-1:0]  d_loss_q;
  logic [LoadDW-1:0]  d_load_q;
  logic [TermW-1:0]   trend_term_q;
  logic               cur_q, last_q;

  // Terms, product and accumulator.
  logic [TermW-1:0]   lat_term_q, loss_term_q, load_term_q;
  logic [MulAW-1:0]   mul_a;
  logic [MulBW-1:0]   mul_b;
  logic [ProdW-1:0]   prod_d, prod_q;
  logic [AccW-1:0]    acc_q;

  // Running set state.
  logic [ScoreW-1:0]  best_score_q, in_use_score_q;
  logic [IdW-1:0]     best_id_q;
  logic               have_best_q, in_use_seen_q;

  // Output register.
  logic               out_valid_q;
  logic [IdW-1:0]     out_route_q;
  logic [ScoreW-1:0]  out_score_q;
  logic               out_switch_q, out_found_q;

  // Input field unpacking.
  logic [IdW-1:0]           in_id;
  logic [LatW-1:0]          in_lat;
  logic [LossW-1:0]         in_loss;
  logic [LoadW-1:0]         in_load;
  logic signed [TrendW-1:0] in_trend;
  logic                     in_accept;

  assign in_id     = s_axis_tdata[7:0];
  assign in_lat    = s_axis_tdata[17:8];
  assign in_loss   = s_axis_tdata[31:18];
  assign in_load   = s_axis_tdata[38:32];
  assign in_trend  = s_axis_tdata[54:39];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Distances below the worst values; past the worst the distance is zero.
  logic [LatDW-1:0]  d_lat_in;
  logic [LossDW-1:0] d_loss_in;
  logic [LoadDW-1:0] d_load_in;

  assign d_lat_in  = (in_lat >= LatW'(wrss_pkg::WORST_LAT_MS)) ? '0 :
                     LatDW'(LatW'(wrss_pkg::WORST_LAT_MS) - in_lat);
  assign d_loss_in = (in_loss >= LossW'(wrss_pkg::WORST_LOSS)) ? '0 :
                     LossDW'(LossW'(wrss_pkg::WORST_LOSS) - in_loss);
  assign d_load_in = (in_load >= LoadW'(wrss_pkg::LOAD_FULL)) ? '0 :
                     LoadDW'(LoadW'(wrss_pkg::LOAD_FULL) - in_load);

  // Trend term: one half plus twice the trend in Q0.16, clamped to zero and one.
  logic signed [18:0] trend_raw;
  logic [TermW-1:0]   trend_term_in;

  assign trend_raw = 19'sd32768 + {{2{in_trend[TrendW-1]}}, in_trend, 1'b0};

  always_comb begin
    if (trend_raw[18]) begin
      trend_term_in = '0;
    end else if (trend_raw > 19'sd65536) begin
      trend_term_in = TermW'(wrss_pkg::Q16_ONE);
    end else begin
      trend_term_in = trend_raw[TermW-1:0];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_lat_q   <= wrss_pkg::RST_W_LATENCY;
      w_loss_q  <= wrss_pkg::RST_W_LOSS;
      w_stab_q  <= wrss_pkg::RST_W_STABILITY;
      w_trend_q <= wrss_pkg::RST_W_TREND;
      thr_q     <= wrss_pkg::RST_THRESHOLD;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wrss_pkg::CFG_W_LATENCY:   w_lat_q   <= cfg_data_i[WeightW-1:0];
        wrss_pkg::CFG_W_LOSS:      w_loss_q  <= cfg_data_i[WeightW-1:0];
        wrss_pkg::CFG_W_STABILITY: w_stab_q  <= cfg_data_i[WeightW-1:0];
        wrss_pkg::CFG_W_TREND:     w_trend_q <= cfg_data_i[WeightW-1:0];
        wrss_pkg::CFG_THRESHOLD:   thr_q     <= cfg_data_i[ScoreW-1:0];
        default: ;
      endcase
    end
  end

  // Final step: score compare and switch decision, held until the output
  // register is free when the beat ends a set.
  logic              fin_go;
  logic [ScoreW-1:0] score;
  logic              take_best;
  logic [ScoreW-1:0] best_score_n, in_use_score_n;
  logic [IdW-1:0]    best_id_n;
  logic              seen_n, switch_n;

  assign fin_go = (state_q == S_DONE) && (!last_q || !out_valid_q || m_axis_tready);
  assign score  = acc_q[AccW-1:16];
  assign take_best      = !have_best_q || (score > best_score_q);
  assign best_score_n   = take_best ? score : best_score_q;
  assign best_id_n      = take_best ? id_q : best_id_q;
  assign in_use_score_n = cur_q ? score : in_use_score_q;
  assign seen_n         = cur_q || in_use_seen_q;
  assign switch_n       = !seen_n ||
      ({1'b0, best_score_n} > ({1'b0, in_use_score_n} + {1'b0, thr_q}));

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_accept) state_d = S_MUL_LAT;
      S_MUL_LAT:  state_d = S_MUL_LOSS;
      S_MUL_LOSS: state_d = S_MUL_LOAD;
      S_MUL_LOAD: state_d = S_W_LAT;
      S_W_LAT:    state_d = S_W_LOSS;
      S_W_LOSS:   state_d = S_W_LOAD;
      S_W_LOAD:   state_d = S_W_TREND;
      S_W_TREND:  state_d = S_ACC;
      S_ACC:      state_d = S_DONE;
      S_DONE:     if (fin_go) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MUL_LAT: begin
        mul_a = MulAW'(wrss_pkg::LAT_RECIP);
        mul_b = MulBW'(d_lat_q);
      end
      S_MUL_LOSS: begin
        mul_a = MulAW'(wrss_pkg::LOSS_RECIP);
        mul_b = MulBW'(d_loss_q);
      end
      S_MUL_LOAD: begin
        mul_a = MulAW'(wrss_pkg::LOAD_RECIP);
        mul_b = MulBW'(d_load_q);
      end
      S_W_LAT: begin
        mul_a = MulAW'(w_lat_q);
        mul_b = lat_term_q;
      end
      S_W_LOSS: begin
        mul_a = MulAW'(w_loss_q);
        mul_b = loss_term_q;
      end
      S_W_LOAD: begin
        mul_a = MulAW'(w_stab_q);
        mul_b = load_term_q;
      end
      S_W_TREND: begin
        mul_a = MulAW'(w_trend_q);
        mul_b = trend_term_q;
      end
      default: ;
    endcase
  end

  assign prod_d = ProdW'(mul_a) * ProdW'(mul_b);

  // Candidate capture, term write-back and accumulation.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (in_accept) begin
      id_q         <= in_id;
      d_lat_q      <= d_lat_in;
      d_loss_q     <= d_loss_in;
      d_load_q     <= d_load_in;
      trend_term_q <= trend_term_in;
      cur_q        <= s_axis_tuser;
      last_q       <= s_axis_tlast;
    end
    case (state_q)
      S_MUL_LOSS: lat_term_q  <= prod_q[wrss_pkg::LAT_SHIFT +: TermW];
      S_MUL_LOAD: loss_term_q <= prod_q[wrss_pkg::LOSS_SHIFT +: TermW];
      S_W_LAT:    load_term_q <= prod_q[wrss_pkg::LOAD_SHIFT +: TermW];
      S_W_LOSS:   acc_q       <= prod_q[AccW-1:0];
      S_W_LOAD, S_W_TREND, S_ACC: acc_q <= acc_q + prod_q[AccW-1:0];
      default: ;
    endcase
  end

  // Running best and in-use score of the current set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_score_q   <= '0;
      best_id_q      <= '0;
      have_best_q    <= 1'b0;
      in_use_score_q <= '0;
      in_use_seen_q  <= 1'b0;
    end else if (fin_go) begin
      if (last_q) begin
        best_score_q   <= '0;
        best_id_q      <= '0;
        have_best_q    <= 1'b0;
        in_use_score_q <= '0;
        in_use_seen_q  <= 1'b0;
      end else begin
        best_score_q   <= best_score_n;
        best_id_q      <= best_id_n;
        have_best_q    <= 1'b1;
        in_use_score_q <= in_use_score_n;
        in_use_seen_q  <= seen_n;
      end
    end
  end

  // Output register: loaded when a set ends, freed when the beat is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go && last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go && last_q) begin
      out_route_q  <= best_id_n;
      out_score_q  <= best_score_n;
      out_switch_q <= switch_n;
      out_found_q  <= seen_n;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_found_q, out_switch_q, out_score_q, out_route_q};

  // A result beat appears only right after a set-ending candidate finishes.
  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE && last_q))
    else $error("result beat raised without a finished set-ending candidate");

  // An accepted candidate always starts the sequence at the first product.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_MUL_LAT))
    else $error("accepted candidate did not start the sequence");

  // Finishing a set clears the running state for the next set.
  a_set_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_go && last_q) |=> (!have_best_q && !in_use_seen_q))
    else $error("set state not cleared after the set ended");

  // The in-use score is one of the set's scores, so it never beats the best.
  a_best_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (have_best_q && in_use_seen_q) |-> (best_score_q >= in_use_score_q))
    else $error("in-use score exceeds running best score");

  // Without an in-use route the switch flag must be set.
  a_switch_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_switch_q) |-> out_found_q)
    else $error("switch flag low while no in-use route was seen");

endmodule
